[hdl/bss_pkg.sv]
// Shared widths, codes and controller/datapath types for the sector splitter.
package bss_pkg;

    localparam int BO_W    = 40;  // byte offset
    localparam int BC_W    = 14;  // byte count
    localparam int LBA_W   = 31;  // sector address
    localparam int SEC_W   = 6;   // sectors per command
    localparam int BUF_W   = 14;  // caller buffer offset
    localparam int SS_W    = 12;  // first used byte in sector
    localparam int SE_W    = 13;  // byte past last used in sector
    localparam int KIND_W  = 3;
    localparam int SHIFT_W = 4;
    localparam int CHUNK_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 31;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 4'd9;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd12;

    // register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK    = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        K_RANGE  = 3'd0,
        K_MERGE  = 3'd1,
        K_PART   = 3'd2,
        K_REJECT = 3'd3,
        K_EMPTY  = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_CHECK,
        ST_PLAN,
        ST_DISPATCH,
        ST_HEAD_MERGE,
        ST_HEAD_PART,
        ST_TAIL_MERGE,
        ST_TAIL_PART,
        ST_RANGE,
        ST_FINAL
    } t_state;

    // which command the datapath loads into the output register
    typedef enum logic [2:0] {
        EM_HEAD_MERGE,
        EM_HEAD_PART,
        EM_TAIL_MERGE,
        EM_TAIL_PART,
        EM_RANGE,
        EM_REJECT,
        EM_EMPTY
    } t_emit;

    typedef struct packed {
        logic  take_in;
        logic  do_add;
        logic  do_check;
        logic  do_plan;
        logic  emit;
        t_emit sel;
        logic  last;
    } t_dp_cmd;

    typedef struct packed {
        logic reject;
        logic empty;
        logic has_head;
        logic head_merge;
        logic has_tail;
        logic wr;
        logic range_more;
        logic range_last;
        logic out_free;
    } t_dp_stat;

endpackage

[hdl/bss_if.sv]
// Valid/ready channel interfaces: request, command and config write.
interface bss_req_if import bss_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [BO_W-1:0] byte_offset;
    logic [BC_W-1:0] byte_count;
    logic            func;

    modport source (output valid, byte_offset, byte_count, func, input ready);
    modport sink   (input valid, byte_offset, byte_count, func, output ready);
endinterface

interface bss_cmd_if import bss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LBA_W-1:0]  cmd_lba;
    logic [SEC_W-1:0]  cmd_sectors;
    logic              cmd_write;
    logic [BUF_W-1:0]  buf_offset;
    logic [SS_W-1:0]   sector_start;
    logic [SE_W-1:0]   sector_end;
    logic [KIND_W-1:0] kind;
    logic              last;

    modport source (output valid, cmd_lba, cmd_sectors, cmd_write, buf_offset,
                    sector_start, sector_end, kind, last, input ready);
    modport sink   (input valid, cmd_lba, cmd_sectors, cmd_write, buf_offset,
                    sector_start, sector_end, kind, last, output ready);
endinterface

interface bss_cfg_if import bss_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

[hdl/bss_datapath.sv]
// Datapath: config registers, request math, range stepping and output register.
module bss_datapath import bss_pkg::*; #(
    parameter int MAX_BYTES = 16384
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [BO_W-1:0]  i_byte_offset,
    input  logic [BC_W-1:0]  i_byte_count,
    input  logic             i_func,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    bss_cfg_if.sink          i_cfg,
    bss_cmd_if.source        o_cmd
);

    localparam int MB_W  = $clog2(MAX_BYTES + 1);
    localparam int CMP_W = (BC_W > MB_W) ? BC_W : MB_W;

    // config
    logic [SHIFT_W-1:0] r_sector_shift;
    logic [LBA_W-1:0]   r_sector_count;
    logic [CHUNK_W-1:0] r_max_chunk;

    // request and derived values
    logic [BO_W-1:0]    r_off;
    logic [BC_W-1:0]    r_cnt;
    logic               r_wr;
    logic [BO_W:0]      r_endb;
    logic [BO_W+2:0]    r_cap;
    logic               r_cnt_bad;
    logic               r_reject;
    logic               r_empty;
    logic [LBA_W-1:0]   r_first;
    logic [LBA_W-1:0]   r_endl;
    logic [SS_W-1:0]    r_so;
    logic [SS_W-1:0]    r_eo;
    logic               r_has_head;
    logic               r_head_merge;
    logic [SE_W-1:0]    r_head_end;
    logic               r_has_tail;
    logic [LBA_W-1:0]   r_cur;
    logic [BUF_W-1:0]   r_buf;

    // output register
    logic               r_valid;
    logic [LBA_W-1:0]   r_lba;
    logic [SEC_W-1:0]   r_secs;
    logic               r_cwr;
    logic [BUF_W-1:0]   r_obuf;
    logic [SS_W-1:0]    r_ostart;
    logic [SE_W-1:0]    r_oend;
    t_kind              r_kind;
    logic               r_last;

    logic [SHIFT_W-1:0] w_sh;
    logic [SE_W-1:0]    w_ss;
    logic [SS_W-1:0]    w_mask;
    logic [CHUNK_W-1:0] w_chunk;
    logic [LBA_W-1:0]   w_rem;
    logic               w_range_last;
    logic [CHUNK_W-1:0] w_take;
    logic               w_single;
    logic               w_ends_first;
    logic               w_short;
    logic [SE_W-1:0]    w_head_end;

    logic [LBA_W-1:0]   n_lba;
    logic [SEC_W-1:0]   n_secs;
    logic               n_cwr;
    logic [BUF_W-1:0]   n_obuf;
    logic [SS_W-1:0]    n_ostart;
    logic [SE_W-1:0]    n_oend;
    t_kind              n_kind;

    always_comb begin
        if (r_sector_shift < SHIFT_MIN) begin
            w_sh = SHIFT_MIN;
        end else if (r_sector_shift > SHIFT_MAX) begin
            w_sh = SHIFT_MAX;
        end else begin
            w_sh = r_sector_shift;
        end
    end

    assign w_ss    = SE_W'(1) << w_sh;
    assign w_mask  = SS_W'(w_ss - SE_W'(1));
    assign w_chunk = (r_max_chunk == '0) ? CHUNK_W'(1) : r_max_chunk;

    // range stepping
    assign w_rem        = r_endl - r_cur;
    assign w_range_last = (w_rem <= LBA_W'(w_chunk));
    assign w_take       = w_range_last ? w_rem[CHUNK_W-1:0] : w_chunk;

    // plan: one-sector request, or one ending right at its first sector's end
    assign w_single     = (r_first == r_endl);
    assign w_ends_first = ({1'b0, r_endl} == ({1'b0, r_first} + (LBA_W+1)'(1)))
                          && (r_eo == '0);
    assign w_short      = w_single || w_ends_first;
    assign w_head_end   = w_single ? {1'b0, r_eo} : w_ss;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_shift <= SHIFT_MIN;
            r_sector_count <= LBA_W'(1);
            r_max_chunk    <= CHUNK_W'(8);
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                CFG_SECTOR_SHIFT: r_sector_shift <= i_cfg.data[SHIFT_W-1:0];
                CFG_SECTOR_COUNT: r_sector_count <= i_cfg.data[LBA_W-1:0];
                CFG_MAX_CHUNK:    r_max_chunk    <= i_cfg.data[CHUNK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_off <= i_byte_offset;
            r_cnt <= i_byte_count;
            r_wr  <= i_func;
        end
        if (i_cmd.do_add) begin
            r_endb    <= {1'b0, r_off} + (BO_W+1)'(r_cnt);
            r_cap     <= (BO_W+3)'(r_sector_count) << w_sh;
            r_cnt_bad <= CMP_W'(r_cnt) >= CMP_W'(MAX_BYTES);
        end
        if (i_cmd.do_check) begin
            r_reject <= r_cnt_bad || ({2'b0, r_endb} >= r_cap);
            r_empty  <= (r_cnt == '0);
            r_first  <= LBA_W'(r_off >> w_sh);
            r_endl   <= LBA_W'(r_endb >> w_sh);
            r_so     <= r_off[SS_W-1:0] & w_mask;
            r_eo     <= r_endb[SS_W-1:0] & w_mask;
        end
        if (i_cmd.do_plan) begin
            r_has_head   <= w_short || (r_so != '0);
            r_head_end   <= w_head_end;
            r_head_merge <= r_wr && ((r_so != '0) || (w_head_end != w_ss));
            r_has_tail   <= !w_short && (r_eo != '0);
            if (w_short) begin
                r_cur <= r_endl;
                r_buf <= '0;
            end else if (r_so != '0) begin
                r_cur <= r_first + LBA_W'(1);
                r_buf <= BUF_W'(w_ss - {1'b0, r_so});
            end else begin
                r_cur <= r_first;
                r_buf <= '0;
            end
        end else if (i_cmd.emit && (i_cmd.sel == EM_RANGE)) begin
            r_cur <= r_cur + LBA_W'(w_take);
            r_buf <= r_buf + BUF_W'((20)'(w_take) << w_sh);
        end
    end

    always_comb begin
        n_lba    = '0;
        n_secs   = SEC_W'(1);
        n_cwr    = 1'b0;
        n_obuf   = '0;
        n_ostart = '0;
        n_oend   = '0;
        n_kind   = K_EMPTY;
        case (i_cmd.sel)
            EM_HEAD_MERGE, EM_HEAD_PART: begin
                n_lba    = r_first;
                n_ostart = r_so;
                n_oend   = r_head_end;
                n_cwr    = (i_cmd.sel == EM_HEAD_PART) ? r_wr : 1'b0;
                n_kind   = (i_cmd.sel == EM_HEAD_PART) ? K_PART : K_MERGE;
            end
            EM_TAIL_MERGE, EM_TAIL_PART: begin
                n_lba  = r_endl;
                n_obuf = r_cnt - BUF_W'(r_eo);
                n_oend = {1'b0, r_eo};
                n_cwr  = (i_cmd.sel == EM_TAIL_PART) ? r_wr : 1'b0;
                n_kind = (i_cmd.sel == EM_TAIL_PART) ? K_PART : K_MERGE;
            end
            EM_RANGE: begin
                n_lba  = r_cur;
                n_secs = w_take[SEC_W-1:0];
                n_cwr  = r_wr;
                n_obuf = r_buf;
                n_kind = K_RANGE;
            end
            EM_REJECT: begin
                n_secs = '0;
                n_kind = K_REJECT;
            end
            default: begin
                n_secs = '0;
                n_kind = K_EMPTY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (o_cmd.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_lba    <= n_lba;
            r_secs   <= n_secs;
            r_cwr    <= n_cwr;
            r_obuf   <= n_obuf;
            r_ostart <= n_ostart;
            r_oend   <= n_oend;
            r_kind   <= n_kind;
            r_last   <= i_cmd.last;
        end
    end

    assign o_cmd.valid        = r_valid;
    assign o_cmd.cmd_lba      = r_lba;
    assign o_cmd.cmd_sectors  = r_secs;
    assign o_cmd.cmd_write    = r_cwr;
    assign o_cmd.buf_offset   = r_obuf;
    assign o_cmd.sector_start = r_ostart;
    assign o_cmd.sector_end   = r_oend;
    assign o_cmd.kind         = r_kind;
    assign o_cmd.last         = r_last;

    assign o_stat.reject     = r_reject;
    assign o_stat.empty      = r_empty;
    assign o_stat.has_head   = r_has_head;
    assign o_stat.head_merge = r_head_merge;
    assign o_stat.has_tail   = r_has_tail;
    assign o_stat.wr         = r_wr;
    assign o_stat.range_more = (r_cur < r_endl);
    assign o_stat.range_last = w_range_last;
    assign o_stat.out_free   = !r_valid || o_cmd.ready;

`ifndef SYNTH
    a_range_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && (i_cmd.sel == EM_RANGE)) |-> (w_take != '0))
        else $error("range command with zero sectors");
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(i_cmd.emit))
        else $error("output valid without a load");
`endif

endmodule

[hdl/bss_ctrl.sv]
// Controller: sequences the request checks and the command emission order.
module bss_ctrl import bss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_req_ready    = 1'b0;
        o_cmd.take_in  = 1'b0;
        o_cmd.do_add   = 1'b0;
        o_cmd.do_check = 1'b0;
        o_cmd.do_plan  = 1'b0;
        o_cmd.emit     = 1'b0;
        o_cmd.sel      = EM_EMPTY;
        o_cmd.last     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = ST_ADD;
                end
            end
            ST_ADD: begin
                o_cmd.do_add = 1'b1;
                n_state      = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.do_check = 1'b1;
                n_state        = ST_PLAN;
            end
            ST_PLAN: begin
                o_cmd.do_plan = 1'b1;
                n_state       = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                if (i_stat.reject || i_stat.empty) begin
                    n_state = ST_FINAL;
                end else if (i_stat.has_head) begin
                    n_state = i_stat.head_merge ? ST_HEAD_MERGE : ST_HEAD_PART;
                end else if (i_stat.has_tail) begin
                    n_state = i_stat.wr ? ST_TAIL_MERGE : ST_TAIL_PART;
                end else begin
                    n_state = ST_RANGE;
                end
            end
            ST_HEAD_MERGE: begin
                o_cmd.sel = EM_HEAD_MERGE;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_HEAD_PART;
                end
            end
            ST_HEAD_PART: begin
                o_cmd.sel  = EM_HEAD_PART;
                o_cmd.last = !i_stat.has_tail && !i_stat.range_more;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.has_tail) begin
                        n_state = i_stat.wr ? ST_TAIL_MERGE : ST_TAIL_PART;
                    end else if (i_stat.range_more) begin
                        n_state = ST_RANGE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_TAIL_MERGE: begin
                o_cmd.sel = EM_TAIL_MERGE;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_TAIL_PART;
                end
            end
            ST_TAIL_PART: begin
                o_cmd.sel  = EM_TAIL_PART;
                o_cmd.last = !i_stat.range_more;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.range_more ? ST_RANGE : ST_IDLE;
                end
            end
            ST_RANGE: begin
                o_cmd.sel  = EM_RANGE;
                o_cmd.last = i_stat.range_last;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.range_last ? ST_IDLE : ST_RANGE;
                end
            end
            ST_FINAL: begin
                o_cmd.sel  = i_stat.reject ? EM_REJECT : EM_EMPTY;
                o_cmd.last = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("load into a full output register");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == ST_IDLE))
        else $error("final command did not end the request");
`endif

endmodule

[hdl/byte_range_sector_splitter_unit.sv]
// Top level of the byte range to sector command splitter.
// Usage:
//   i_req  : one item is a byte request (byte_offset, byte_count, func).
//   o_cmd  : one item is a sector command; last marks the final one of a request.
//   i_cfg  : register writes (0 sector_shift, 1 sector_count, 2 max_chunk_sectors),
//            always ready; write only while no request is in flight.
// Each request gives 1 to 35 commands: head merge/transfer, tail merge/transfer,
// then middle ranges of at most max_chunk_sectors sectors, or one reject/empty item.
// The first command becomes valid after the add, device-end check, plan and
// dispatch states and the load into the output register. Further commands follow
// one per cycle while the receiver takes them, through the single output register,
// set by the controller's emit states. i_req.ready is high only while the controller
// is idle, so a new request waits until all earlier commands are loaded; it is taken
// while the final command still waits in the output register.
// A stalled receiver holds the output register; emission pauses until it drains.
// Reset (i_rst_n low, synchronous): controller idle, output empty, registers back
// to sector_shift 9, sector_count 1, max_chunk_sectors 8.
module byte_range_sector_splitter_unit import bss_pkg::*; #(
    parameter int MAX_BYTES = 16384
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bss_req_if.sink   i_req,
    bss_cmd_if.source o_cmd,
    bss_cfg_if.sink   i_cfg
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_req_ready;

    assign i_req.ready = w_req_ready;

    // sequencing only; all arithmetic sits in the datapath
    bss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bss_datapath #(
        .MAX_BYTES (MAX_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_offset (i_req.byte_offset),
        .i_byte_count  (i_req.byte_count),
        .i_func        (i_req.func),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg         (i_cfg),
        .o_cmd         (o_cmd)
    );

endmodule
